### design/ugbt_pkg.sv
package ugbt_pkg;

	localparam int MaxCells = 256;
	localparam int MaxObjects = 256;
	localparam int SlotsPerCell = 32;
	localparam int CellW = 8;
	localparam int SlotW = 5;
	localparam int FillW = 6;
	localparam int IdW = 8;
	localparam int MemAw = CellW + SlotW;

	localparam logic [1:0] FUNC_ADD_POS = 2'd0;
	localparam logic [1:0] FUNC_ADD_CELL = 2'd1;
	localparam logic [1:0] FUNC_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	localparam logic [1:0] REG_CELL_SIZE = 2'd0;
	localparam logic [1:0] REG_COLUMNS = 2'd1;
	localparam logic [1:0] REG_ROWS = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_CELL,
		S_LOOKUP,
		S_ADD,
		S_REM_RD,
		S_REM_WR,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic cell_calc;
		logic lookup;
		logic add_commit;
		logic rem_read;
		logic rem_commit;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic is_add_pos;
		logic is_add_cell;
		logic is_remove;
	} stat_t;

endpackage

### design/ugbt_ctrl.sv
module ugbt_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  ugbt_pkg::stat_t stat,
	output ugbt_pkg::cmd_t cmd,
	output logic busy
);
	import ugbt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DIV;
			end
			S_DIV: begin
				if (!stat.is_add_pos) state_d = S_LOOKUP;
				else if (stat.div_done) state_d = S_CELL;
			end
			S_CELL: state_d = S_LOOKUP;
			S_LOOKUP: begin
				if (stat.is_remove) state_d = S_REM_RD;
				else if (stat.is_add_pos || stat.is_add_cell) state_d = S_ADD;
				else state_d = S_DONE;
			end
			S_ADD: state_d = S_DONE;
			S_REM_RD: state_d = S_REM_WR;
			S_REM_WR: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: cmd.load = start;
			S_DIV: cmd.div_step = 1'b1;
			S_CELL: cmd.cell_calc = 1'b1;
			S_LOOKUP: cmd.lookup = 1'b1;
			S_ADD: cmd.add_commit = 1'b1;
			S_REM_RD: cmd.rem_read = 1'b1;
			S_REM_WR: cmd.rem_commit = 1'b1;
			S_DONE: cmd.emit = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

### design/ugbt_datapath.sv
module ugbt_datapath (
	input  logic clk,
	input  logic arst_n,
	input  ugbt_pkg::cmd_t cmd,
	output ugbt_pkg::stat_t stat,
	input  logic [14:0] cell_size,
	input  logic [4:0] columns,
	input  logic [4:0] rows,
	input  logic [1:0] func,
	input  logic [7:0] object_id,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [7:0] target_cell,
	output logic done,
	output logic [1:0] status,
	output logic [7:0] cell_index,
	output logic [4:0] slot_index,
	output logic [7:0] moved_object,
	output logic moved_valid
);
	import ugbt_pkg::*;

	logic [MaxObjects-1:0] placed_q;
	logic [MaxCells-1:0] fill_valid_q;
	logic [CellW-1:0] home_mem [MaxObjects];
	logic [SlotW-1:0] slot_mem [MaxObjects];
	logic [FillW-1:0] fill_mem [MaxCells];
	logic [IdW-1:0] member_mem [MaxCells*SlotsPerCell];

	logic [1:0] func_q;
	logic [IdW-1:0] id_q;
	logic [CellW-1:0] cell_q;
	logic [14:0] cs_q;
	logic [4:0] ecols, erows;
	logic [8:0] ncells;
	logic [15:0] qx_q, qy_q, rx_q, ry_q;
	logic negx_q, negy_q;
	logic [4:0] dcnt_q;
	logic [FillW-1:0] fill_q;
	logic [CellW-1:0] home_q;
	logic [SlotW-1:0] slot_q;
	logic [IdW-1:0] moved_q;
	logic [1:0] st_q;
	logic [CellW-1:0] oc_q;
	logic [SlotW-1:0] os_q;
	logic [IdW-1:0] om_q;
	logic omv_q, done_q;
	logic rem_pend_q;
	logic [FillW-1:0] last_q;

	assign ecols = (columns == 5'd0) ? 5'd1 : ((columns > 5'd16) ? 5'd16 : columns);
	assign erows = (rows == 5'd0) ? 5'd1 : ((rows > 5'd16) ? 5'd16 : rows);
	assign ncells = 9'(ecols * erows);

	assign stat.div_done = (dcnt_q == 5'd16);
	assign stat.is_add_pos = (func_q == FUNC_ADD_POS);
	assign stat.is_add_cell = (func_q == FUNC_ADD_CELL);
	assign stat.is_remove = (func_q == FUNC_REMOVE);

	// restoring divide step for both axes
	logic [16:0] trx, try_;
	assign trx = {rx_q, qx_q[15]} - {2'b0, cs_q};
	assign try_ = {ry_q, qy_q[15]} - {2'b0, cs_q};

	// clamp quotients
	logic [4:0] cx, cy;
	logic [8:0] lin;
	assign cx = negx_q ? 5'd0 : ((qx_q >= 16'(ecols)) ? ecols - 5'd1 : qx_q[4:0]);
	assign cy = negy_q ? 5'd0 : ((qy_q >= 16'(erows)) ? erows - 5'd1 : qy_q[4:0]);
	assign lin = 9'(cy * ecols) + 9'(cx);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			id_q <= object_id;
			cs_q <= (cell_size == 15'd0) ? 15'd1 : cell_size;
			negx_q <= pos_x[15];
			negy_q <= pos_y[15];
			qx_q <= pos_x;
			qy_q <= pos_y;
			rx_q <= '0;
			ry_q <= '0;
			dcnt_q <= '0;
			cell_q <= ({1'b0, target_cell} >= ncells) ? 8'(ncells - 9'd1) : target_cell;
		end
		if (cmd.div_step && dcnt_q != 5'd16) begin
			if (!trx[16]) rx_q <= trx[15:0];
			else rx_q <= {rx_q[14:0], qx_q[15]};
			qx_q <= {qx_q[14:0], ~trx[16]};
			if (!try_[16]) ry_q <= try_[15:0];
			else ry_q <= {ry_q[14:0], qy_q[15]};
			qy_q <= {qy_q[14:0], ~try_[16]};
			dcnt_q <= dcnt_q + 5'd1;
		end
		if (cmd.cell_calc) begin
			cell_q <= (lin >= ncells) ? 8'(ncells - 9'd1) : lin[7:0];
		end
		if (cmd.lookup) begin
			home_q <= home_mem[id_q];
			slot_q <= slot_mem[id_q];
			fill_q <= fill_valid_q[cell_q] ? fill_mem[cell_q] : '0;
			st_q <= ST_OK; oc_q <= '0; os_q <= '0; om_q <= '0; omv_q <= 1'b0;
		end
		if (cmd.add_commit) begin
			if (placed_q[id_q]) begin
				st_q <= ST_OK; oc_q <= home_q; os_q <= slot_q;
			end else if (fill_q >= 6'(SlotsPerCell)) begin
				st_q <= ST_FULL; oc_q <= cell_q;
			end else begin
				member_mem[{cell_q, fill_q[SlotW-1:0]}] <= id_q;
				fill_mem[cell_q] <= fill_q + 6'd1;
				home_mem[id_q] <= cell_q;
				slot_mem[id_q] <= fill_q[SlotW-1:0];
				st_q <= ST_OK; oc_q <= cell_q; os_q <= fill_q[SlotW-1:0];
			end
		end
		if (cmd.rem_read) begin
			cell_q <= home_q;
			fill_q <= fill_valid_q[home_q] ? fill_mem[home_q] : '0;
			if (!placed_q[id_q]) st_q <= ST_ABSENT;
			else begin
				oc_q <= home_q;
				os_q <= slot_q;
			end
		end
		if (cmd.rem_commit && st_q == ST_OK) begin
			moved_q <= member_mem[{cell_q, 5'(fill_q - 6'd1)}];
			fill_mem[cell_q] <= fill_q - 6'd1;
			last_q <= fill_q - 6'd1;
		end
		// second half of removal: write the moved member and, if it came from a later slot, update its slot
		if (rem_pend_q) begin
			member_mem[{cell_q, os_q}] <= moved_q;
			if ({1'b0, os_q} < last_q) begin
				slot_mem[moved_q] <= os_q;
				om_q <= moved_q;
				omv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			placed_q <= '0;
			fill_valid_q <= '0;
			rem_pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			rem_pend_q <= 1'b0;
			if (cmd.add_commit && !placed_q[id_q] && fill_q < 6'(SlotsPerCell)) begin
				placed_q[id_q] <= 1'b1;
				fill_valid_q[cell_q] <= 1'b1;
			end
			if (cmd.rem_commit && st_q == ST_OK) begin
				placed_q[id_q] <= 1'b0;
				fill_valid_q[cell_q] <= 1'b1;
				rem_pend_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign status = st_q;
	assign cell_index = oc_q;
	assign slot_index = os_q;
	assign moved_object = om_q;
	assign moved_valid = omv_q;

endmodule

### design/uniform_grid_bucket_table_core.sv
// channel   | handshake                  | payload
// command   | start, busy                | func, object_id, pos_x, pos_y, target_cell
// result    | done (one-cycle strobe)    | status, cell_index, slot_index, moved_object,
//           |                            | moved_valid
// config    | apb psel/penable/pwrite    | paddr, pwdata, prdata
// add by position runs 16 steps of the two-axis restoring divider, both axes in parallel
// add to cell, remove and an unused func do not wait for the divider; they run only their memory steps
// one transaction at a time; busy stays high until the result strobe
// arst_n clears placement and fill valid bits at once, no clearing pass
// the receiver cannot stall; results are dropped only if not sampled
module uniform_grid_bucket_table_core (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] func,
	input  logic [7:0] object_id,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [7:0] target_cell,
	output logic done,
	output logic [1:0] status,
	output logic [7:0] cell_index,
	output logic [4:0] slot_index,
	output logic [7:0] moved_object,
	output logic moved_valid,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import ugbt_pkg::*;

	logic [14:0] cell_size_q;
	logic [4:0] columns_q, rows_q;
	cmd_t cmd;
	stat_t stat;
	logic [1:0] reg_sel;

	assign pready = 1'b1;
	assign reg_sel = paddr[3:2];

	// config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= 15'd64;
			columns_q <= 5'd16;
			rows_q <= 5'd16;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (reg_sel)
				REG_CELL_SIZE: cell_size_q <= pwdata[14:0];
				REG_COLUMNS: columns_q <= pwdata[4:0];
				REG_ROWS: rows_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// readback
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			case (reg_sel)
				REG_CELL_SIZE: prdata = {17'd0, cell_size_q};
				REG_COLUMNS: prdata = {27'd0, columns_q};
				REG_ROWS: prdata = {27'd0, rows_q};
				default: prdata = '0;
			endcase
		end
	end

	ugbt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
	);

	ugbt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cell_size(cell_size_q), .columns(columns_q), .rows(rows_q),
		.func(func), .object_id(object_id), .pos_x(pos_x), .pos_y(pos_y),
		.target_cell(target_cell), .done(done), .status(status),
		.cell_index(cell_index), .slot_index(slot_index),
		.moved_object(moved_object), .moved_valid(moved_valid)
	);

endmodule

### tb/sv/uniform_grid_bucket_table_core_test.sv
module uniform_grid_bucket_table_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ugbt_pkg::*;

	// one result transaction as the grid would report it
	typedef struct {
		logic [1:0] status;
		logic [7:0] grid_cell;
		logic [4:0] slot;
		logic [7:0] moved;
		logic       moved_ok;
	} grid_result_t;

	// mirror of the bucket table plus the queue of results still owed by the block
	class grid_scoreboard;
		bit       placed[MaxObjects];
		bit [7:0] home[MaxObjects];
		bit [4:0] slot_of[MaxObjects];
		bit [5:0] fill[MaxCells];
		bit [7:0] members[MaxCells][SlotsPerCell];
		bit [14:0] cell_size = 15'd64;
		bit [4:0]  columns = 5'd16;
		bit [4:0]  rows = 5'd16;
		grid_result_t owed[$];
		int errors = 0;

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_CELL_SIZE: cell_size = value[14:0];
				REG_COLUMNS:   columns = value[4:0];
				REG_ROWS:      rows = value[4:0];
				default: ;
			endcase
		endfunction

		function int grid_cols();
			if (columns == 0) return 1;
			return (columns > 16) ? 16 : int'(columns);
		endfunction

		function int grid_rows();
			if (rows == 0) return 1;
			return (rows > 16) ? 16 : int'(rows);
		endfunction

		// truncating division then clamp; any negative coordinate lands on 0
		function int axis_pick(logic signed [15:0] coord, int limit);
			int divisor;
			int q;
			divisor = (cell_size == 0) ? 1 : int'(cell_size);
			if (coord[15]) return 0;
			q = int'(coord[14:0]) / divisor;
			return (q >= limit) ? limit - 1 : q;
		endfunction

		function grid_result_t place(int id, int bucket);
			grid_result_t r;
			int f;
			r = '{ST_OK, 8'd0, 5'd0, 8'd0, 1'b0};
			if (placed[id]) begin
				r.grid_cell = home[id];
				r.slot = slot_of[id];
				return r;
			end
			f = fill[bucket];
			if (f >= SlotsPerCell) begin
				r.status = ST_FULL;
				r.grid_cell = bucket[7:0];
				return r;
			end
			members[bucket][f] = id[7:0];
			fill[bucket] = f + 1;
			placed[id] = 1'b1;
			home[id] = bucket[7:0];
			slot_of[id] = f[4:0];
			r.grid_cell = bucket[7:0];
			r.slot = f[4:0];
			return r;
		endfunction

		// swap-with-last removal
		function grid_result_t unplace(int id);
			grid_result_t r;
			int h;
			int s;
			int last;
			bit [7:0] mover;
			r = '{ST_OK, 8'd0, 5'd0, 8'd0, 1'b0};
			if (!placed[id]) begin
				r.status = ST_ABSENT;
				return r;
			end
			h = home[id];
			s = slot_of[id];
			placed[id] = 1'b0;
			r.grid_cell = h[7:0];
			r.slot = s[4:0];
			if (fill[h] == 0 || s >= fill[h]) return r;
			last = fill[h] - 1;
			mover = members[h][last];
			members[h][s] = mover;
			fill[h] = last[5:0];
			if (s < last) begin
				slot_of[mover] = s[4:0];
				r.moved = mover;
				r.moved_ok = 1'b1;
			end
			return r;
		endfunction

		function void note_command(logic [1:0] f, logic [7:0] id, logic signed [15:0] x,
				logic signed [15:0] y, logic [7:0] target);
			int cells;
			int bucket;
			grid_result_t r;
			cells = grid_cols() * grid_rows();
			if (cells > MaxCells) cells = MaxCells;
			case (f)
				FUNC_ADD_POS: begin
					bucket = axis_pick(y, grid_rows()) * grid_cols() + axis_pick(x, grid_cols());
					if (bucket >= cells) bucket = cells - 1;
					r = place(id, bucket);
				end
				FUNC_ADD_CELL: begin
					bucket = target;
					if (bucket >= cells) bucket = cells - 1;
					r = place(id, bucket);
				end
				FUNC_REMOVE: r = unplace(id);
				default: r = '{ST_OK, 8'd0, 5'd0, 8'd0, 1'b0};
			endcase
			owed = {owed, r};
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_result(grid_result_t got);
			grid_result_t want;
			if (owed.size() == 0) begin
				report("result with no command outstanding");
				return;
			end
			want = owed.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, predicted %0d", got.status, want.status));
			if (got.grid_cell !== want.grid_cell)
				report($sformatf("cell_index %0d, predicted %0d", got.grid_cell,
					want.grid_cell));
			if (got.slot !== want.slot)
				report($sformatf("slot_index %0d, predicted %0d", got.slot, want.slot));
			if (got.moved !== want.moved)
				report($sformatf("moved_object %0d, predicted %0d", got.moved, want.moved));
			if (got.moved_ok !== want.moved_ok)
				report($sformatf("moved_valid %0b, predicted %0b", got.moved_ok,
					want.moved_ok));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] func = FUNC_ADD_POS;
	logic [7:0] object_id = '0;
	logic signed [15:0] pos_x = '0;
	logic signed [15:0] pos_y = '0;
	logic [7:0] target_cell = '0;
	logic done;
	logic [1:0] status;
	logic [7:0] cell_index;
	logic [4:0] slot_index;
	logic [7:0] moved_object;
	logic moved_valid;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	grid_scoreboard grid = new();
	int cycle_count = 0;
	int commands_sent = 0;

	uniform_grid_bucket_table_core DUT (.*);

	// 8 ns clock
	always #4 clk = ~clk;

	// watchdog, far beyond the slowest legal run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 600000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result strobe is one cycle wide, so sample every edge
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			grid.check_result('{status, cell_index, slot_index, moved_object, moved_valid});
	end

	// apb write: setup cycle, then access cycle; pready is tied high
	task write_reg(logic [1:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		grid.set_reg(idx, value);
	endtask

	// wait until every result is back, then let the block settle
	task drain();
		start <= 1'b0;
		while (grid.owed.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// one command transaction; start is left high so a burst can continue
	task issue(logic [1:0] f, logic [7:0] id, logic signed [15:0] x,
			logic signed [15:0] y, logic [7:0] target);
		start <= 1'b1;
		func <= f;
		object_id <= id;
		pos_x <= x;
		pos_y <= y;
		target_cell <= target;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		grid.note_command(f, id, x, y, target);
		commands_sent++;
	endtask

	task issue_one(logic [1:0] f, logic [7:0] id, logic signed [15:0] x,
			logic signed [15:0] y, logic [7:0] target);
		issue(f, id, x, y, target);
		start <= 1'b0;
		@(posedge clk);
	endtask

	// mostly small ids so removes hit placed objects, sometimes the full range
	function logic [7:0] pick_id();
		return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 63));
	endfunction

	function logic [7:0] pick_placed();
		int base;
		base = $urandom_range(0, 255);
		for (int k = 0; k < MaxObjects; k++)
			if (grid.placed[(base + k) % MaxObjects]) return 8'((base + k) % MaxObjects);
		return pick_id();
	endfunction

	// coordinates mostly inside the grid, some anywhere in the 16-bit range
	function logic signed [15:0] pick_coord(int span);
		int c;
		int top;
		c = $urandom_range(0, 9);
		top = (grid.cell_size == 0 ? 1 : int'(grid.cell_size)) * (span + 1);
		if (top > 32767) top = 32767;
		if (c < 6) return 16'($urandom_range(0, top));
		if (c < 8) return 16'($urandom);
		return -16'sd1 - 16'($urandom_range(0, 40));
	endfunction

	task random_command();
		int c;
		c = $urandom_range(0, 99);
		if (c < 36)
			issue(FUNC_ADD_POS, pick_id(), pick_coord(grid.grid_cols()),
				pick_coord(grid.grid_rows()), 8'($urandom));
		else if (c < 60)
			issue(FUNC_ADD_CELL, pick_id(), 16'($urandom), 16'($urandom),
				($urandom_range(0, 4) == 0) ? 8'($urandom)
				: 8'($urandom_range(0, grid.grid_cols() * grid.grid_rows() - 1)));
		else if (c < 96)
			issue(FUNC_REMOVE, ($urandom_range(0, 4) == 0) ? pick_id() : pick_placed(),
				16'($urandom), 16'($urandom), 8'($urandom));
		else
			issue(2'd3, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
	endtask

	// try to stuff one cell past capacity with random ids, then remove some placed objects
	task fill_cell();
		logic [7:0] target;
		logic [7:0] id;
		target = 8'($urandom_range(0, grid.grid_cols() * grid.grid_rows() - 1));
		for (int k = 0; k < 34; k++) begin
			id = 8'($urandom);
			issue(FUNC_ADD_CELL, id, 16'($urandom), 16'($urandom), target);
		end
		for (int k = 0; k < 20; k++)
			issue(FUNC_REMOVE, pick_placed(), 16'($urandom), 16'($urandom), 8'($urandom));
	endtask

	// reconfigure while idle, then bursts of random commands with random gaps
	task run_phase(logic [31:0] size, logic [31:0] cols, logic [31:0] rws, int count);
		int stop_at;
		int burst;
		drain();
		write_reg(REG_CELL_SIZE, size);
		write_reg(REG_COLUMNS, cols);
		write_reg(REG_ROWS, rws);
		stop_at = commands_sent + count;
		while (commands_sent < stop_at) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst && commands_sent < stop_at; k++) begin
				if ($urandom_range(0, 59) == 0) fill_cell();
				else random_command();
			end
			start <= 1'b0;
			case ($urandom_range(0, 9))
				0, 1, 2: @(posedge clk);
				3: drain();
				default: repeat ($urandom_range(1, 15)) @(posedge clk);
			endcase
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: coordinate extremes, saturation, swap and no-swap removal
		issue_one(FUNC_ADD_POS, 8'd0, 16'sd0, 16'sd0, 8'd0);
		issue_one(FUNC_ADD_POS, 8'd255, 16'sd32767, 16'sd32767, 8'd0);
		issue_one(FUNC_ADD_POS, 8'd1, -16'sd32768, -16'sd1, 8'd0);
		issue_one(FUNC_ADD_POS, 8'd2, -16'sd1, 16'sd32767, 8'd0);
		issue_one(FUNC_ADD_CELL, 8'd3, 16'sd0, 16'sd0, 8'd255);
		issue_one(FUNC_ADD_CELL, 8'd4, 16'sd0, 16'sd0, 8'd0);
		issue_one(FUNC_ADD_POS, 8'd0, 16'sd500, 16'sd500, 8'd0);
		issue_one(FUNC_REMOVE, 8'd0, 16'sd0, 16'sd0, 8'd0);
		issue_one(FUNC_REMOVE, 8'd0, 16'sd0, 16'sd0, 8'd0);
		issue_one(FUNC_REMOVE, 8'd4, 16'sd0, 16'sd0, 8'd0);
		issue_one(FUNC_REMOVE, 8'd1, 16'sd0, 16'sd0, 8'd0);
		issue_one(2'd3, 8'd170, 16'sh5555, 16'shAAAA, 8'd170);
		issue_one(FUNC_ADD_CELL, 8'd85, 16'sd0, 16'sd0, 8'd170);
		issue_one(FUNC_ADD_POS, 8'd170, 16'sd63, 16'sd64, 8'd0);
		issue_one(FUNC_REMOVE, 8'd255, 16'sd0, 16'sd0, 8'd0);
		issue_one(FUNC_REMOVE, 8'd3, 16'sd0, 16'sd0, 8'd0);
		issue_one(FUNC_REMOVE, 8'd2, 16'sd0, 16'sd0, 8'd0);
		issue_one(FUNC_REMOVE, 8'd85, 16'sd0, 16'sd0, 8'd0);
		issue_one(FUNC_REMOVE, 8'd170, 16'sd0, 16'sd0, 8'd0);

		// settings sweep: reset grid, single cell, huge cells, degenerate values, odd shapes
		run_phase(32'd64, 32'd16, 32'd16, 260);
		run_phase(32'd1, 32'd1, 32'd1, 200);
		run_phase(32'd32767, 32'd16, 32'd16, 160);
		run_phase(32'd0, 32'd0, 32'd31, 200);
		run_phase(32'd1000, 32'd5, 32'd3, 200);
		run_phase(32'd7, 32'd31, 32'd0, 160);
		run_phase($urandom_range(1, 32767), $urandom_range(1, 16), $urandom_range(1, 16), 250);

		drain();
		if (grid.owed.size() != 0)
			grid.report("results still outstanding at end of run");
		if (grid.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
